// ===== rtl/core/dls_pkg.sv =====
`timescale 1ns / 1ps

package dls_pkg;

	localparam int DLS_DEPTH = 64;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 7;

	// s_tdata carries value only, m_tdata carries found, position and count
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_INS_FRONT = 3'd0;
	localparam op_t OP_INS_BACK  = 3'd1;
	localparam op_t OP_REM_FRONT = 3'd2;
	localparam op_t OP_REM_BACK  = 3'd3;
	localparam op_t OP_SEARCH    = 3'd4;

	localparam status_t STAT_DONE  = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;

endpackage

// ===== rtl/core/double_ended_list_with_search.sv =====
`timescale 1ns / 1ps

// Bounded double-ended list of up to DEPTH signed 32-bit values held in a circular
// store, with insert and remove at either end and a linear search from
// the front. Every operation beat on the slave side gives exactly one result beat on
// the master side. Inserts, removes and unused op codes finish in the cycle they are
// accepted, so their result is offered on the next cycle. A search walks the live
// entries through one shared compare unit, one entry per cycle behind the registered
// read of the store: a search that finds the key stops at that entry, a miss reads
// every live entry, and a search of an empty list finishes at once. No new beat is
// taken while a search runs or while an earlier result is still held and not being
// taken in the same cycle.
module double_ended_list_with_search #(
	parameter int DEPTH = dls_pkg::DLS_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dls_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
	input  logic [dls_pkg::OP_W-1:0]      s_tuser,  // [2:0] op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dls_pkg::M_TDATA_W-1:0] m_tdata,  // [0] found, [7:1] position,
	                                                // [14:8] count, [15] zero
	output logic [dls_pkg::STATUS_W-1:0]  m_tuser   // [1:0] status
);
	import dls_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_W   = (CW+1)'(DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                 state_q;
	logic [AW-1:0]        front_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        ptr_q;
	logic [CW-1:0]        issue_q;
	logic                 m_tvalid_q;
	logic                 rd_vld_s1;
	logic [CW-1:0]        rd_idx_s1;
	logic [VALUE_W-1:0]   rd_data_s1;
	logic [VALUE_W-1:0]   key_q;
	status_t              out_status_q;
	logic                 out_found_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [POS_W-1:0]     out_cnt_q;

	logic [VALUE_W-1:0]   mem [DEPTH];

	op_t                  op;
	logic                 acc;
	logic                 full;
	logic                 empty;
	logic [AW-1:0]        front_dec;
	logic [AW-1:0]        front_inc;
	logic [AW-1:0]        ptr_inc;
	logic [CW:0]          back_sum;
	logic [AW-1:0]        back_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	status_t              res_status;
	logic [CW-1:0]        res_cnt;
	logic                 start_scan;
	logic                 issuing;
	logic                 hit;
	logic [CW-1:0]        last_idx;
	logic                 scan_done;
	logic                 set_result;

	assign op       = s_tuser;
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - 1'b1;
	assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + 1'b1;
	assign ptr_inc   = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;

	// back slot is front plus count, wrapped once
	assign back_sum  = (CW+1)'(front_q) + (CW+1)'(count_q);
	assign back_addr = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = back_addr;
		res_status = STAT_DONE;
		res_cnt    = count_q;
		start_scan = 1'b0;
		unique case (op)
			OP_INS_FRONT: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					wr_en   = acc;
					wr_addr = front_dec;
					res_cnt = count_q + 1'b1;
				end
			end
			OP_INS_BACK: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					wr_en   = acc;
					res_cnt = count_q + 1'b1;
				end
			end
			OP_REM_FRONT, OP_REM_BACK: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					res_cnt = count_q - 1'b1;
				end
			end
			OP_SEARCH: begin
				start_scan = !empty;
			end
			default: begin
			end
		endcase
	end

	assign issuing   = (state_q == ST_SCAN) && (issue_q < count_q);
	assign hit       = (rd_data_s1 == key_q);
	assign last_idx  = count_q - 1'b1;
	assign scan_done = (state_q == ST_SCAN) && rd_vld_s1 && (hit || rd_idx_s1 == last_idx);

	// a new result beat is loaded by a quick operation or the end of a search
	assign set_result = (acc && !start_scan) || scan_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			ptr_q      <= '0;
			issue_q    <= '0;
			m_tvalid_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (set_result) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (acc) begin
						count_q <= res_cnt;
						if (op == OP_INS_FRONT && !full) begin
							front_q <= front_dec;
						end
						if (op == OP_REM_FRONT && !empty) begin
							front_q <= front_inc;
						end
						if (start_scan) begin
							state_q <= ST_SCAN;
							ptr_q   <= front_q;
							issue_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						ptr_q   <= ptr_inc;
						issue_q <= issue_q + 1'b1;
					end
					rd_vld_s1 <= issuing && !scan_done;
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// store and read stage of the scan
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= s_tdata;
		end
		rd_data_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (issuing) begin
			rd_idx_s1 <= issue_q;
		end
		if (acc) begin
			key_q        <= s_tdata;
			out_status_q <= res_status;
			out_found_q  <= 1'b0;
			out_pos_q    <= (op == OP_SEARCH) ? POS_W'(count_q) : '0;
			out_cnt_q    <= POS_W'(res_cnt);
		end else if (scan_done) begin
			out_found_q <= hit;
			out_pos_q   <= hit ? POS_W'(rd_idx_s1) : POS_W'(count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_pos_q, out_found_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond depth");

	a_no_result_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !m_tvalid_q)
		else $error("result offered while a search is running");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op != OP_SEARCH) |=> m_tvalid_q)
		else $error("quick operation gave no result beat");

	a_scan_stops: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> (state_q == ST_IDLE) && !rd_vld_s1 && m_tvalid_q)
		else $error("search did not close cleanly");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("read stage busy outside a search");

endmodule
